>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define BFE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also holds through reset
`define BFE_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> design/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg
// Types and constants of the Boltzmann free energy block.
// ----------------------------------------------------------------------------
package bfe_pkg;

  // request and result payloads
  typedef struct packed {
    logic signed [31:0] level_energy;
    logic               last_level;
  } level_t;

  typedef struct packed {
    logic signed [31:0] f_energy;
    logic signed [31:0] mean_energy;
    logic               saturated;
  } result_t;

  // shared multiplier: round(a*b / 2^shift), all ones on overflow
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  shift;
  } mul_req_t;

  // shared divider: num * 2^bits / den
  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic [5:0]  bits;
  } div_req_t;

  typedef struct packed {
    logic [63:0] quo;
    logic        rnd;
    logic        big;
  } div_res_t;

  // configuration
  localparam int unsigned ADDR_W     = 3;
  localparam logic        REG_TEMP   = 1'b0;
  localparam logic [30:0] TEMP_RESET = 31'd65536;

  // fixed point constants
  localparam logic [63:0] ONE60  = 64'h1000_0000_0000_0000;
  localparam logic [63:0] ONE61  = 64'h2000_0000_0000_0000;
  localparam logic [63:0] FRAC32 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] Q40    = 64'h0000_0100_0000_0000;
  localparam logic [63:0] I32_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] I32_MIN = 64'hFFFF_FFFF_8000_0000;
  // 1/3 in Q.60, rounded to nearest
  localparam logic [63:0] THIRD60 = 64'h0555_5555_5555_5555;

  // shift codes of the multiplier
  localparam logic [5:0] SH_NONE = 6'd0;
  localparam logic [5:0] SH_FRAC = 6'd32;
  localparam logic [5:0] SH_LN   = 6'd56;
  localparam logic [5:0] SH_Q60  = 6'd60;

  // series lengths
  localparam logic [4:0] EXP_TERMS   = 5'd24;
  localparam logic [4:0] ATANH_TERMS = 5'd23;

endpackage

>>> design/bfe_mul.sv
// ----------------------------------------------------------------------------
// bfe_mul
// Iterative 64x64 multiplier with rounding right shift and saturation,
// built from one 32x32 multiplier over four partial products.
// ----------------------------------------------------------------------------
module bfe_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bfe_pkg::mul_req_t req,
  output logic              done,
  output logic [63:0]       prod
);
  import bfe_pkg::*;

  logic [63:0]  a;
  logic [63:0]  b;
  logic [5:0]   sh;
  logic [2:0]   cnt;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   pp_off;
  logic [127:0] acc;
  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [127:0] pp_ext;
  logic [127:0] rnd_add;
  logic [127:0] sum;
  logic [127:0] shifted;

  // operand halves and alignment of the registered partial product
  always_comb begin
    a_part  = cnt[0] ? a[63:32] : a[31:0];
    b_part  = cnt[1] ? b[63:32] : b[31:0];
    pp_ext  = {64'd0, pp} << {pp_off, 5'd0};
    rnd_add = (sh == SH_NONE) ? 128'd0 : (128'd1 << (sh - 6'd1));
    sum     = acc + rnd_add;
    shifted = sum >> sh;
  end

  // sequence: four products, four accumulations, one rounding step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        a    <= req.a;
        b    <= req.b;
        sh   <= req.shift;
        cnt  <= 3'd0;
        acc  <= 128'd0;
      end else if (busy) begin
        if (cnt <= 3'd3) begin
          pp     <= a_part * b_part;
          pp_off <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
        end
        if (cnt >= 3'd1 && cnt <= 3'd4) begin
          acc <= acc + pp_ext;
        end
        if (cnt == 3'd5) begin
          prod <= (|shifted[127:64]) ? {64{1'b1}} : shifted[63:0];
          done <= 1'b1;
          busy <= 1'b0;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

>>> design/bfe_div.sv
// ----------------------------------------------------------------------------
// bfe_div
// Bit-serial restoring divider: one quotient bit per cycle, with the
// round-half-up bit and a flag for quotient bits lost off the top.
// ----------------------------------------------------------------------------
module bfe_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bfe_pkg::div_req_t req,
  output logic              done,
  output bfe_pkg::div_res_t res
);
  import bfe_pkg::*;

  logic [63:0] num_sh;
  logic [63:0] den;
  logic [63:0] rem;
  logic [63:0] quo;
  logic        big;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] rem2;
  logic        ge;
  logic [64:0] rem_n;

  // one restoring step
  always_comb begin
    rem2  = {rem, num_sh[63]};
    ge    = rem2 >= {1'b0, den};
    rem_n = ge ? rem2 - {1'b0, den} : rem2;
    res.quo = quo;
    res.big = big;
    res.rnd = {rem, 1'b0} >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        num_sh <= req.num;
        den    <= req.den;
        rem    <= 64'd0;
        quo    <= 64'd0;
        big    <= 1'b0;
        cnt    <= 7'd64 + {1'b0, req.bits};
      end else if (busy) begin
        num_sh <= {num_sh[62:0], 1'b0};
        rem    <= rem_n[63:0];
        quo    <= {quo[62:0], ge};
        big    <= big | quo[63];
        cnt    <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/bfe_seq.sv
// ----------------------------------------------------------------------------
// bfe_seq
// Sequencer and state of the block: per level weight, sum update, and on
// the last level the log and mean, all through the shared mul and div.
// ----------------------------------------------------------------------------
module bfe_seq #(
  parameter int MAX_LEVELS       = 4096,
  parameter int WEIGHT_FRAC_BITS = 31
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  bfe_pkg::level_t  lvl,
  input  logic [30:0]      temperature,
  input  logic             out_free,
  output logic             ready,
  output logic             res_load,
  output bfe_pkg::result_t res
);
  import bfe_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int ZW    = WEIGHT_FRAC_BITS + CNT_W;
  localparam int WW    = WEIGHT_FRAC_BITS + 1;
  localparam logic [63:0]      ONE     = 64'd1 << WEIGHT_FRAC_BITS;
  localparam logic [63:0]      W_HALF  = 64'd1 << (59 - WEIGHT_FRAC_BITS);
  localparam logic [5:0]       SH_W    = 6'(WEIGHT_FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEVELS);

  typedef enum logic [4:0] {
    S_IDLE, S_LEVEL, S_W_DIV, S_W_EXPF, S_W_E1, S_W_KMUL, S_W_ROUND,
    S_APPLY, S_A_ZMUL, S_A_WMUL, S_A_EMUL, S_ENDCHK,
    S_EXP_MUL, S_EXP_DIV, S_AT_SQ, S_AT_MUL, S_AT_DIV,
    S_R_LN2, S_R_NORM, S_R_DIVU, S_R_LNM, S_R_NMUL,
    S_R_TMUL, S_R_DIVW, S_R_EMIT
  } state_t;

  state_t state;
  state_t ret;

  // block state
  logic signed [31:0] e;
  logic               last;
  logic signed [31:0] e0;
  logic [ZW-1:0]      ws;
  logic [63:0]        wsum;
  logic [CNT_W-1:0]   count;
  logic               ovf;

  // working registers
  logic               newmin;
  logic [WW-1:0]      wt;
  logic [4:0]         k;
  logic [63:0]        p;
  logic [63:0]        e1;
  logic [63:0]        acc;
  logic [63:0]        term;
  logic [63:0]        fac;
  logic [4:0]         idx;
  logic [63:0]        ln2;
  logic [ZW-1:0]      z;
  logic [63:0]        mm;
  logic [5:0]         shcnt;
  logic [6:0]         nexp;
  logic [63:0]        lnz;
  logic [63:0]        fe;
  logic [63:0]        qm;

  // shared units
  logic     mul_start;
  mul_req_t mul_req;
  logic     mul_done;
  logic [63:0] mul_prod;
  logic     div_start;
  div_req_t div_req;
  logic     div_done;
  div_res_t div_res;

  // helpers
  logic [32:0] diff;
  logic [31:0] span;
  logic [30:0] temp_eff;
  logic [63:0] dr;
  logic [63:0] esx;
  logic [63:0] emag;
  logic [63:0] wmag;
  logic [63:0] wround;
  logic [63:0] lnm;
  logic [63:0] ln2q;
  logic [63:0] zmax;
  logic [63:0] me;
  logic        fe_hi;
  logic        fe_lo;
  logic        me_hi;
  logic        me_lo;

  bfe_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  bfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .res   (div_res)
  );

  // distance to the lowest level, magnitudes, rounding and clamps
  always_comb begin
    diff     = {e[31], e} - {e0[31], e0};
    span     = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
    temp_eff = (temperature == 31'd0) ? 31'd1 : temperature;
    dr       = div_res.quo + 64'(div_res.rnd);
    esx      = {{32{e[31]}}, e};
    emag     = e[31] ? 64'd0 - esx : esx;
    wmag     = wsum[63] ? 64'd0 - wsum : wsum;
    wround   = (p + W_HALF) >> (60 - WEIGHT_FRAC_BITS);
    lnm      = {acc[62:0], 1'b0};
    ln2q     = (ln2 + 64'd8) >> 4;
    zmax     = (64'(ws) < ONE) ? ONE : 64'(ws);
    me       = wsum[63] ? 64'd0 - qm : qm;
    fe_hi    = $signed(fe) > $signed(I32_MAX);
    fe_lo    = $signed(fe) < $signed(I32_MIN);
    me_hi    = $signed(me) > $signed(I32_MAX);
    me_lo    = $signed(me) < $signed(I32_MIN);
  end

  assign ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      e0        <= 32'sd0;
      ws        <= '0;
      wsum      <= 64'd0;
      count     <= '0;
      ovf       <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      res_load  <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      res_load  <= 1'b0;
      unique case (state)
        // take a level
        S_IDLE: begin
          if (take) begin
            e     <= lvl.level_energy;
            last  <= lvl.last_level;
            state <= S_LEVEL;
          end
        end
        S_LEVEL: begin
          if (count >= CNT_MAX) begin
            ovf   <= 1'b1;
            state <= S_ENDCHK;
          end else if (count == '0) begin
            e0    <= e;
            ws    <= ZW'(ONE);
            wsum  <= esx;
            count <= CNT_W'(1);
            state <= S_ENDCHK;
          end else begin
            newmin    <= (e < e0);
            div_start <= 1'b1;
            div_req   <= '{num: 64'(span), den: 64'(temp_eff), bits: SH_FRAC};
            state     <= S_W_DIV;
          end
        end
        // weight: split distance/T into integer and fraction
        S_W_DIV: begin
          if (div_done) begin
            if (div_res.big || (|div_res.quo[63:37])) begin
              wt    <= '0;
              state <= S_APPLY;
            end else begin
              k         <= div_res.quo[36:32];
              acc       <= ONE60;
              term      <= ONE60;
              fac       <= {32'd0, div_res.quo[31:0]} + 64'(div_res.rnd);
              idx       <= 5'd1;
              mul_start <= 1'b1;
              mul_req   <= '{a: ONE60,
                             b: {32'd0, div_res.quo[31:0]} + 64'(div_res.rnd),
                             shift: SH_FRAC};
              ret       <= S_W_EXPF;
              state     <= S_EXP_MUL;
            end
          end
        end
        S_W_EXPF: begin
          p <= acc;
          if (k == 5'd0) begin
            state <= S_W_ROUND;
          end else begin
            acc       <= ONE60;
            term      <= ONE60;
            fac       <= FRAC32;
            idx       <= 5'd1;
            mul_start <= 1'b1;
            mul_req   <= '{a: ONE60, b: FRAC32, shift: SH_FRAC};
            ret       <= S_W_E1;
            state     <= S_EXP_MUL;
          end
        end
        S_W_E1: begin
          e1        <= acc;
          mul_start <= 1'b1;
          mul_req   <= '{a: p, b: acc, shift: SH_Q60};
          state     <= S_W_KMUL;
        end
        // one factor of exp(-1) per integer step
        S_W_KMUL: begin
          if (mul_done) begin
            p <= mul_prod;
            k <= k - 5'd1;
            if (k == 5'd1) begin
              state <= S_W_ROUND;
            end else begin
              mul_start <= 1'b1;
              mul_req   <= '{a: mul_prod, b: e1, shift: SH_Q60};
            end
          end
        end
        S_W_ROUND: begin
          wt    <= (wround > ONE) ? WW'(ONE) : WW'(wround);
          state <= S_APPLY;
        end
        // update the sums
        S_APPLY: begin
          mul_start <= 1'b1;
          if (newmin) begin
            mul_req <= '{a: 64'(ws), b: 64'(wt), shift: SH_W};
            state   <= S_A_ZMUL;
          end else begin
            ws      <= ws + ZW'(wt);
            mul_req <= '{a: emag, b: 64'(wt), shift: SH_W};
            state   <= S_A_EMUL;
          end
        end
        S_A_ZMUL: begin
          if (mul_done) begin
            ws        <= ZW'(mul_prod + ONE);
            mul_start <= 1'b1;
            mul_req   <= '{a: wmag, b: 64'(wt), shift: SH_W};
            state     <= S_A_WMUL;
          end
        end
        S_A_WMUL: begin
          if (mul_done) begin
            wsum  <= (wsum[63] ? 64'd0 - mul_prod : mul_prod) + esx;
            e0    <= e;
            count <= count + CNT_W'(1);
            state <= S_ENDCHK;
          end
        end
        S_A_EMUL: begin
          if (mul_done) begin
            wsum  <= wsum + (e[31] ? 64'd0 - mul_prod : mul_prod);
            count <= count + CNT_W'(1);
            state <= S_ENDCHK;
          end
        end
        // on the last level, ln2 first as 2*atanh(1/3)
        S_ENDCHK: begin
          if (last) begin
            term      <= THIRD60;
            acc       <= THIRD60;
            mul_start <= 1'b1;
            mul_req   <= '{a: THIRD60, b: THIRD60, shift: SH_Q60};
            ret       <= S_R_LN2;
            state     <= S_AT_SQ;
          end else begin
            state <= S_IDLE;
          end
        end
        // exp(-f) series, returns in acc
        S_EXP_MUL: begin
          if (mul_done) begin
            div_start <= 1'b1;
            div_req   <= '{num: mul_prod, den: 64'(idx), bits: SH_NONE};
            state     <= S_EXP_DIV;
          end
        end
        S_EXP_DIV: begin
          if (div_done) begin
            term <= dr;
            if (idx[0]) begin
              acc <= (acc >= dr) ? acc - dr : 64'd0;
            end else begin
              acc <= acc + dr;
            end
            if (idx == EXP_TERMS) begin
              state <= ret;
            end else begin
              idx       <= idx + 5'd1;
              mul_start <= 1'b1;
              mul_req   <= '{a: dr, b: fac, shift: SH_FRAC};
              state     <= S_EXP_MUL;
            end
          end
        end
        // atanh series, half the result in acc
        S_AT_SQ: begin
          if (mul_done) begin
            fac       <= mul_prod;
            idx       <= 5'd1;
            mul_start <= 1'b1;
            mul_req   <= '{a: term, b: mul_prod, shift: SH_Q60};
            state     <= S_AT_MUL;
          end
        end
        S_AT_MUL: begin
          if (mul_done) begin
            term      <= mul_prod;
            div_start <= 1'b1;
            div_req   <= '{num: mul_prod, den: {58'd0, idx, 1'b1}, bits: SH_NONE};
            state     <= S_AT_DIV;
          end
        end
        S_AT_DIV: begin
          if (div_done) begin
            acc <= acc + dr;
            if (idx == ATANH_TERMS) begin
              state <= ret;
            end else begin
              idx       <= idx + 5'd1;
              mul_start <= 1'b1;
              mul_req   <= '{a: term, b: fac, shift: SH_Q60};
              state     <= S_AT_MUL;
            end
          end
        end
        S_R_LN2: begin
          ln2   <= lnm;
          z     <= ZW'(zmax);
          mm    <= zmax;
          shcnt <= 6'd0;
          state <= S_R_NORM;
        end
        // normalize z to [1,2) one bit a cycle
        S_R_NORM: begin
          if (mm[61]) begin
            nexp      <= 7'd61 - 7'(shcnt) - 7'(WEIGHT_FRAC_BITS);
            div_start <= 1'b1;
            div_req   <= '{num: mm - ONE61, den: mm + ONE61, bits: SH_Q60};
            state     <= S_R_DIVU;
          end else begin
            mm    <= {mm[62:0], 1'b0};
            shcnt <= shcnt + 6'd1;
          end
        end
        S_R_DIVU: begin
          if (div_done) begin
            term      <= dr;
            acc       <= dr;
            mul_start <= 1'b1;
            mul_req   <= '{a: dr, b: dr, shift: SH_Q60};
            ret       <= S_R_LNM;
            state     <= S_AT_SQ;
          end
        end
        S_R_LNM: begin
          lnz       <= (lnm + 64'd8) >> 4;
          mul_start <= 1'b1;
          mul_req   <= '{a: 64'(nexp), b: ln2q, shift: SH_NONE};
          state     <= S_R_NMUL;
        end
        S_R_NMUL: begin
          if (mul_done) begin
            mul_start <= 1'b1;
            mul_req   <= '{a: 64'(temp_eff), b: mul_prod + lnz, shift: SH_LN};
            state     <= S_R_TMUL;
          end
        end
        S_R_TMUL: begin
          if (mul_done) begin
            fe        <= {{32{e0[31]}}, e0} - mul_prod;
            div_start <= 1'b1;
            div_req   <= '{num: wmag, den: 64'(z), bits: SH_W};
            state     <= S_R_DIVW;
          end
        end
        S_R_DIVW: begin
          if (div_done) begin
            qm    <= (dr > Q40) ? Q40 : dr;
            state <= S_R_EMIT;
          end
        end
        // emit once the output register is free, then clear
        S_R_EMIT: begin
          if (out_free) begin
            res_load        <= 1'b1;
            res.f_energy    <= fe_hi ? I32_MAX[31:0] : (fe_lo ? I32_MIN[31:0] : fe[31:0]);
            res.mean_energy <= me_hi ? I32_MAX[31:0] : (me_lo ? I32_MIN[31:0] : me[31:0]);
            res.saturated   <= ovf | fe_hi | fe_lo | me_hi | me_lo;
            e0    <= 32'sd0;
            ws    <= '0;
            wsum  <= 64'd0;
            count <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/boltzmann_free_energy.sv
// ----------------------------------------------------------------------------
// boltzmann_free_energy
// Free energy E0 - T*ln(Z) and mean energy W/Z of a set of energy levels.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  level     in   level_valid/level_ready    level_t  (energy, last mark)
//  result    out  result_valid/result_ready  result_t (F, U, saturated)
//  config    in   APB psel/penable/pwrite    temperature at 0x0
//
//  one request at a time through a shared bit-serial divider and a 64x64
//  multiplier built from four partial products; a first or dropped level
//  skips the weight; a later level needs one exponential, two when the
//  distance is T or more, none when its weight is flushed to zero, and one
//  multiply per integer step of distance/T; the last level adds log and mean
//  reset is synchronous and clears the sums; a held result stalls only the
//  end of the next set, new levels are still taken
// ----------------------------------------------------------------------------
module boltzmann_free_energy #(
  parameter int MAX_LEVELS       = 4096,
  parameter int WEIGHT_FRAC_BITS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        level_valid,
  output logic                        level_ready,
  input  bfe_pkg::level_t             level,
  output logic                        result_valid,
  input  logic                        result_ready,
  output bfe_pkg::result_t            result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfe_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bfe_pkg::*;

  logic [30:0] temperature;
  logic        take;
  logic        out_free;
  logic        res_load;
  result_t     res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_TEMP) ? {1'b0, temperature} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature <= TEMP_RESET;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_TEMP) begin
      temperature <= pwdata[30:0];
    end
  end

  assign take     = level_valid && level_ready;
  assign out_free = !result_valid || result_ready;

  bfe_seq #(
    .MAX_LEVELS       (MAX_LEVELS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .lvl         (level),
    .temperature (temperature),
    .out_free    (out_free),
    .ready       (level_ready),
    .res_load    (res_load),
    .res         (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

endmodule

>>> design/bfe_chk.sv
// ----------------------------------------------------------------------------
// bfe_chk
// Port checker for the Boltzmann free energy block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfe_chk (
  input logic             clk,
  input logic             rst,
  input logic             level_valid,
  input logic             level_ready,
  input logic             result_valid,
  input logic             result_ready,
  input bfe_pkg::result_t result
);
  import bfe_pkg::*;

  // a held result stays up
  `BFE_ASSERT(a_res_hold, clk, rst, result_valid && !result_ready |=> result_valid)
  // a held result keeps its value
  `BFE_ASSERT(a_res_stable, clk, rst, result_valid && !result_ready |=> $stable(result))
  // a taken level keeps the block busy
  `BFE_ASSERT(a_busy_after_take, clk, rst, level_valid && level_ready |=> !level_ready)
  // reset leaves no result and an idle block
  `BFE_ASSERT_NR(a_reset_idle, clk, rst |=> !result_valid && level_ready)

endmodule

bind boltzmann_free_energy bfe_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .level_valid  (level_valid),
  .level_ready  (level_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
